FILE: src/tdr_pkg.sv
// Shared types and constants of the triangle depth rasteriser
package tdr_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SETUP,
    ST_PIXEL,
    ST_EDGE,
    ST_DIV,
    ST_READ,
    ST_TEST,
    ST_EMIT
  } state_t;

  localparam int CoordW = 13;
  localparam int DepthW = 16;
  localparam int ColorW = 24;
  localparam int EdgeW  = 28;
  localparam int NumW   = 46;
  localparam int DenW   = 28;
  localparam logic [ColorW-1:0] FillReset = 24'hFF0000;

endpackage

FILE: src/tdr_if.sv
// Valid/ready channel interfaces for rasteriser words
interface tdr_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic signed [12:0] vertex_a_x;
  logic signed [12:0] vertex_a_y;
  logic [15:0] vertex_a_depth;
  logic signed [12:0] vertex_b_x;
  logic signed [12:0] vertex_b_y;
  logic [15:0] vertex_b_depth;
  logic signed [12:0] vertex_c_x;
  logic signed [12:0] vertex_c_y;
  logic [15:0] vertex_c_depth;
  logic [7:0]  tile_col;
  logic [6:0]  tile_row;
  modport source (output valid, action, vertex_a_x, vertex_a_y, vertex_a_depth,
    vertex_b_x, vertex_b_y, vertex_b_depth, vertex_c_x, vertex_c_y, vertex_c_depth,
    tile_col, tile_row, input ready);
  modport sink (input valid, action, vertex_a_x, vertex_a_y, vertex_a_depth,
    vertex_b_x, vertex_b_y, vertex_b_depth, vertex_c_x, vertex_c_y, vertex_c_depth,
    tile_col, tile_row, output ready);
endinterface

interface tdr_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] pixel_x;
  logic [9:0]  pixel_y;
  logic [15:0] pixel_depth;
  logic [23:0] pixel_color;
  logic        last;
  modport source (output valid, pixel_x, pixel_y, pixel_depth, pixel_color, last,
    input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_depth, pixel_color, last,
    output ready);
endinterface

FILE: src/tdr_ram.sv
// Generic single-port RAM with registered read
module tdr_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: src/tdr_div.sv
// Restoring divider, one quotient bit per cycle, saturating to 16 bits
module tdr_div
  import tdr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NumW-1:0]   num,
  input  logic [DenW-1:0]   den,
  output logic              done,
  output logic [DepthW-1:0] quot
);
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q;
  logic [DenW:0]   rem;
  logic [DenW-1:0] d;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DenW:0]   trial;

  assign trial = {rem[DenW-1:0], q[NumW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= num;
        d    <= den;
        rem  <= '0;
        cnt  <= CntW'(NumW);
      end else if (busy) begin
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          q   <= {q[NumW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = (q[NumW-1:DepthW] != '0) ? '1 : q[DepthW-1:0];
endmodule

FILE: src/triangle_depth_rasterizer_unit.sv
// Top level: tile scan sequencer with shared edge unit, divider and depth store
// Sequence: a setup step after a raster word is taken; per pixel, the edge values in turn on
// the shared edge unit and, if covered, the numerator, the 46-step divider, a depth read and
// a test with a write on pass; a closing emit step ends a tile that passes setup.
// Throughput: one word at a time, taken only while idle with no word held at the output.
// Reset and clear: one store entry a cycle, SCREEN_WIDTH*SCREEN_HEIGHT in all; reset fill 0xFF0000.
module triangle_depth_rasterizer_unit
  import tdr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 1280,
  parameter int SCREEN_HEIGHT = 720,
  parameter int TILE_SIZE     = 8
) (
  input  logic              clk,
  input  logic              rst,
  tdr_in_if.sink            in_ch,
  tdr_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [ColorW-1:0] cfg_wdata
);
  localparam int StoreSize = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AddrW     = $clog2(StoreSize);
  localparam int PW        = 14;

  state_t state, state_next;
  logic [ColorW-1:0] fill_color;
  logic signed [CoordW-1:0] xa, ya, xb, yb, xc, yc;
  logic [DepthW-1:0] za, zb, zc;
  logic signed [PW-1:0] minx, maxx, miny, maxy, px, py;
  logic signed [EdgeW-1:0] area, wa, wb, wc;
  logic [1:0] eidx;
  logic [AddrW-1:0] caddr;
  logic [NumW-1:0] num;
  logic [DenW-1:0] den;
  logic [DepthW-1:0] zq;
  logic div_start, div_done;
  logic [DepthW-1:0] quot, rdata;
  logic found;
  logic ram_we;
  logic [AddrW-1:0] ram_addr, paddr;
  logic [DepthW-1:0] ram_wdata;
  logic [10:0] ox;
  logic [9:0] oy;
  logic [DepthW-1:0] oz;
  logic olast, ovalid;
  logic has_prev;

  // setup values
  logic signed [PW-1:0] sminx, smaxx, sminy, smaxy, tx0, ty0;
  logic signed [CoordW-1:0] ax, ay, bx, by, cx, cy;
  always_comb begin
    ax = in_ch.vertex_a_x; ay = in_ch.vertex_a_y;
    bx = in_ch.vertex_b_x; by = in_ch.vertex_b_y;
    cx = in_ch.vertex_c_x; cy = in_ch.vertex_c_y;
    tx0 = PW'(in_ch.tile_col) * PW'(TILE_SIZE);
    ty0 = PW'(in_ch.tile_row) * PW'(TILE_SIZE);
    sminx = PW'(ax); if (PW'(bx) < sminx) sminx = PW'(bx); if (PW'(cx) < sminx) sminx = PW'(cx);
    smaxx = PW'(ax); if (PW'(bx) > smaxx) smaxx = PW'(bx); if (PW'(cx) > smaxx) smaxx = PW'(cx);
    sminy = PW'(ay); if (PW'(by) < sminy) sminy = PW'(by); if (PW'(cy) < sminy) sminy = PW'(cy);
    smaxy = PW'(ay); if (PW'(by) > smaxy) smaxy = PW'(by); if (PW'(cy) > smaxy) smaxy = PW'(cy);
    if (sminx < PW'(1)) sminx = PW'(1);
    if (sminy < PW'(1)) sminy = PW'(1);
    if (smaxx > PW'(SCREEN_WIDTH - 1)) smaxx = PW'(SCREEN_WIDTH - 1);
    if (smaxy > PW'(SCREEN_HEIGHT - 1)) smaxy = PW'(SCREEN_HEIGHT - 1);
    if (sminx < tx0) sminx = tx0;
    if (sminy < ty0) sminy = ty0;
    if (smaxx > tx0 + PW'(TILE_SIZE - 1)) smaxx = tx0 + PW'(TILE_SIZE - 1);
    if (smaxy > ty0 + PW'(TILE_SIZE - 1)) smaxy = ty0 + PW'(TILE_SIZE - 1);
  end

  // shared edge unit: (x-px)*(qy-py) - (y-py)*(qx-px)
  logic signed [PW-1:0] epx, epy, eqx, eqy, eux, euy;
  logic signed [EdgeW-1:0] eres;
  always_comb begin
    case (eidx)
      2'd0: begin epx = PW'(xb); epy = PW'(yb); eqx = PW'(xc); eqy = PW'(yc); end
      2'd1: begin epx = PW'(xc); epy = PW'(yc); eqx = PW'(xa); eqy = PW'(ya); end
      default: begin epx = PW'(xa); epy = PW'(ya); eqx = PW'(xb); eqy = PW'(yb); end
    endcase
    if (state == ST_SETUP) begin
      eux = PW'(xa); euy = PW'(ya);
    end else begin
      eux = px; euy = py;
    end
    eres = EdgeW'((eux - epx) * (eqy - epy)) - EdgeW'((euy - epy) * (eqx - epx));
  end

  logic covered;
  logic signed [EdgeW-1:0] na, nb, nc;
  always_comb begin
    covered = !(((wa > 0) || (wb > 0) || (wc > 0)) && ((wa < 0) || (wb < 0) || (wc < 0)));
    na = area[EdgeW-1] ? -wa : wa;
    nb = area[EdgeW-1] ? -wb : wb;
    nc = area[EdgeW-1] ? -wc : wc;
  end

  assign paddr = AddrW'(py * PW'(SCREEN_WIDTH) + px);

  tdr_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(num), .den(den),
    .done(div_done), .quot(quot)
  );

  tdr_ram #(.Width(DepthW), .Depth(StoreSize)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(rdata)
  );

  logic last_px;
  assign last_px = (px == maxx) && (py == maxy);

  // the held fragment goes out once the next passing one or the tile end is known
  logic pass, stall, emit_mid, emit_end;
  assign pass     = (state == ST_TEST) && (rdata <= zq);
  assign stall    = pass && has_prev && ovalid && !out_ch.ready;
  assign emit_mid = pass && has_prev && !stall;
  assign emit_end = (state == ST_EMIT) && (!ovalid || out_ch.ready) && has_prev;

  logic found_d;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_ch.valid && !ovalid) begin
        state_next = in_ch.action ? ST_SETUP : ST_CLEAR;
      end
      ST_CLEAR: if (caddr == AddrW'(StoreSize - 1)) state_next = ST_IDLE;
      ST_SETUP: begin
        if (eres == '0 || minx > maxx || miny > maxy) state_next = ST_IDLE;
        else state_next = ST_PIXEL;
      end
      ST_PIXEL: state_next = ST_EDGE;
      ST_EDGE: if (eidx == 2'd2) state_next = ST_DIV;
      ST_DIV: begin
        if (!covered) state_next = last_px ? ST_EMIT : ST_PIXEL;
        else if (div_done) state_next = ST_READ;
      end
      ST_READ: state_next = ST_TEST;
      ST_TEST: if (!stall) state_next = last_px ? ST_EMIT : ST_PIXEL;
      ST_EMIT: if (!ovalid || out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state == ST_IDLE) && !ovalid;
    ram_we      = 1'b0;
    ram_addr    = paddr;
    ram_wdata   = zq;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1; ram_addr = caddr; ram_wdata = '0;
      end
      ST_TEST: ram_we = pass && !stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      caddr      <= '0;
      fill_color <= FillReset;
      ovalid     <= 1'b0;
      has_prev   <= 1'b0;
      eidx       <= '0;
    end else begin
      if (cfg_we) fill_color <= cfg_wdata;
      if (emit_mid || emit_end) begin
        ovalid <= 1'b1; olast <= emit_end;
        out_ch.pixel_x <= ox; out_ch.pixel_y <= oy;
        out_ch.pixel_depth <= oz; out_ch.pixel_color <= fill_color;
      end else if (ovalid && out_ch.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        ST_IDLE: if (in_ch.valid && !ovalid) begin
          caddr <= '0; has_prev <= 1'b0; eidx <= '0;
          xa <= ax; ya <= ay; za <= in_ch.vertex_a_depth;
          xb <= bx; yb <= by; zb <= in_ch.vertex_b_depth;
          xc <= cx; yc <= cy; zc <= in_ch.vertex_c_depth;
          minx <= sminx; maxx <= smaxx; miny <= sminy; maxy <= smaxy;
          px <= sminx; py <= sminy;
        end
        ST_CLEAR: caddr <= caddr + 1'b1;
        ST_SETUP: begin
          area <= eres; eidx <= '0;
          den  <= eres[EdgeW-1] ? DenW'(-eres) : DenW'(eres);
        end
        ST_PIXEL: eidx <= '0;
        ST_EDGE: begin
          case (eidx)
            2'd0: wa <= eres;
            2'd1: wb <= eres;
            default: wc <= eres;
          endcase
          eidx <= eidx + 1'b1;
        end
        default: ;
      endcase
      if (state == ST_EDGE && eidx == 2'd2) begin
        found <= 1'b0;
      end
      if (state == ST_DIV && !found && covered) begin
        num <= NumW'(na[EdgeW-2:0]) * NumW'(za) + NumW'(nb[EdgeW-2:0]) * NumW'(zb)
             + NumW'(nc[EdgeW-2:0]) * NumW'(zc);
        found <= 1'b1;
      end
      if (div_done) zq <= quot;
      if (state == ST_DIV && !covered) begin
        if (px == maxx) begin px <= minx; py <= py + 1'b1; end
        else px <= px + 1'b1;
      end
      if (state == ST_TEST && !stall) begin
        if (px == maxx) begin px <= minx; py <= py + 1'b1; end
        else px <= px + 1'b1;
        if (pass) begin
          has_prev <= 1'b1;
          ox <= 11'(px); oy <= 10'(py); oz <= zq;
        end
      end
      if (emit_end) has_prev <= 1'b0;
      state <= state_next;
    end
  end

  // divider started once the numerator is latched
  always_ff @(posedge clk) begin
    if (rst) found_d <= 1'b0;
    else found_d <= (state == ST_DIV) && !found && covered;
  end
  assign div_start = found_d;

  assign out_ch.valid = ovalid;
  assign out_ch.last  = olast;
endmodule

FILE: dv/triangle_depth_rasterizer_unit_tb.sv
// Testbench for the triangle depth rasteriser: random and directed tiles checked against a fragment predictor
module triangle_depth_rasterizer_unit_tb;
  import tdr_pkg::*;

  localparam int ScrW = 1280;
  localparam int ScrH = 720;
  localparam int Tile = 8;
  localparam int QuietCycles = 5000;

  localparam bit ActClear  = 1'b0;
  localparam bit ActRaster = 1'b1;

  typedef struct {
    bit                    action;
    logic signed [12:0]    ax, ay, bx, by, cx, cy;
    logic [DepthW-1:0]     az, bz, cz;
    logic [7:0]            tcol;
    logic [6:0]            trow;
  } tri_word_t;

  typedef struct {
    logic [10:0]       x;
    logic [9:0]        y;
    logic [DepthW-1:0] z;
    logic [ColorW-1:0] color;
    logic              last;
  } frag_t;

  class frag_scoreboard;
    frag_t             pending[$];
    logic [DepthW-1:0] zbuf[int];
    logic [ColorW-1:0] fill;
    int                errors;

    function new();
      fill = FillReset;
      errors = 0;
    endfunction

    task report(string what);
      $display("ERROR %0t: %s", $time, what);
      errors++;
    endtask

    function longint edge_fn(longint x, longint y, longint px, longint py,
                             longint qx, longint qy);
      return (x - px) * (qy - py) - (y - py) * (qx - px);
    endfunction

    function void note_word(tri_word_t w);
      longint xa, ya, xb, yb, xc, yc, area, x0, y0, x1, y1, wa, wb, wc;
      longint unsigned num, den, z;
      frag_t f;
      int n, idx;
      if (w.action == ActClear) begin
        zbuf.delete();
        return;
      end
      xa = w.ax; ya = w.ay; xb = w.bx; yb = w.by; xc = w.cx; yc = w.cy;
      area = (xa - xb) * (yc - yb) - (ya - yb) * (xc - xb);
      if (area == 0) return;
      x0 = xa < xb ? xa : xb; x0 = x0 < xc ? x0 : xc;
      y0 = ya < yb ? ya : yb; y0 = y0 < yc ? y0 : yc;
      x1 = xa > xb ? xa : xb; x1 = x1 > xc ? x1 : xc;
      y1 = ya > yb ? ya : yb; y1 = y1 > yc ? y1 : yc;
      if (x0 < 1) x0 = 1;
      if (y0 < 1) y0 = 1;
      if (x1 > ScrW - 1) x1 = ScrW - 1;
      if (y1 > ScrH - 1) y1 = ScrH - 1;
      if (x0 < int'(w.tcol) * Tile) x0 = int'(w.tcol) * Tile;
      if (y0 < int'(w.trow) * Tile) y0 = int'(w.trow) * Tile;
      if (x1 > int'(w.tcol) * Tile + Tile - 1) x1 = int'(w.tcol) * Tile + Tile - 1;
      if (y1 > int'(w.trow) * Tile + Tile - 1) y1 = int'(w.trow) * Tile + Tile - 1;
      n = 0;
      for (longint y = y0; y <= y1; y++) begin
        for (longint x = x0; x <= x1; x++) begin
          wa = edge_fn(x, y, xb, yb, xc, yc);
          wb = edge_fn(x, y, xc, yc, xa, ya);
          wc = edge_fn(x, y, xa, ya, xb, yb);
          if ((wa > 0 || wb > 0 || wc > 0) && (wa < 0 || wb < 0 || wc < 0)) continue;
          if (area < 0) begin
            wa = -wa; wb = -wb; wc = -wc; den = -area;
          end else begin
            den = area;
          end
          num = wa * w.az + wb * w.bz + wc * w.cz;
          z = num / den;
          if (z > 16'hFFFF) z = 16'hFFFF;
          idx = int'(y * ScrW + x);
          if (zbuf.exists(idx) && zbuf[idx] > z) continue;
          zbuf[idx] = z[15:0];
          f.x = x[10:0]; f.y = y[9:0]; f.z = z[15:0]; f.color = fill; f.last = 1'b0;
          pending.insert(pending.size(), f);
          n++;
        end
      end
      if (n > 0) pending[pending.size() - 1].last = 1'b1;
    endfunction

    task check_frag(frag_t got);
      frag_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected fragment (%0d,%0d)", got.x, got.y));
        return;
      end
      e = pending.pop_front();
      if (got.x !== e.x) report($sformatf("pixel_x %0d, want %0d", got.x, e.x));
      if (got.y !== e.y) report($sformatf("pixel_y %0d, want %0d", got.y, e.y));
      if (got.z !== e.z)
        report($sformatf("pixel_depth %0d, want %0d at (%0d,%0d)", got.z, e.z, e.x, e.y));
      if (got.color !== e.color)
        report($sformatf("pixel_color %h, want %h", got.color, e.color));
      if (got.last !== e.last) report($sformatf("last %b, want %b", got.last, e.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [ColorW-1:0] cfg_wdata;
  int phase;
  frag_scoreboard sb;

  tdr_in_if  in_ch();
  tdr_out_if out_ch();

  triangle_depth_rasterizer_unit DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function int sender_gap_pct();
    return phase == 0 ? 7 : (phase == 1 ? 61 : 0);
  endfunction

  function int sink_stall_pct();
    return phase == 0 ? 61 : (phase == 1 ? 7 : 0);
  endfunction

  task send_word(tri_word_t w);
    while ($urandom_range(99) < sender_gap_pct()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= w.action;
    in_ch.vertex_a_x <= w.ax; in_ch.vertex_a_y <= w.ay; in_ch.vertex_a_depth <= w.az;
    in_ch.vertex_b_x <= w.bx; in_ch.vertex_b_y <= w.by; in_ch.vertex_b_depth <= w.bz;
    in_ch.vertex_c_x <= w.cx; in_ch.vertex_c_y <= w.cy; in_ch.vertex_c_depth <= w.cz;
    in_ch.tile_col <= w.tcol; in_ch.tile_row <= w.trow;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(w);
  endtask

  task send_tri(int ax, int ay, int az, int bx, int by, int bz,
                int cx, int cy, int cz, int tc, int tr);
    tri_word_t w;
    w.action = ActRaster;
    w.ax = 13'(ax); w.ay = 13'(ay); w.az = 16'(az);
    w.bx = 13'(bx); w.by = 13'(by); w.bz = 16'(bz);
    w.cx = 13'(cx); w.cy = 13'(cy); w.cz = 16'(cz);
    w.tcol = 8'(tc); w.trow = 7'(tr);
    send_word(w);
  endtask

  task wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (QuietCycles) @(posedge clk);
  endtask

  task write_fill(logic [ColorW-1:0] c);
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.fill = c;
  endtask

  task send_random();
    tri_word_t w;
    int ox, oy;
    w.action = ActRaster;
    w.az = 16'($urandom); w.bz = 16'($urandom); w.cz = 16'($urandom);
    if ($urandom_range(9) < 8) begin
      w.tcol = 8'($urandom_range(159)); w.trow = 7'($urandom_range(89));
      ox = int'(w.tcol) * Tile - 12; oy = int'(w.trow) * Tile - 12;
      w.ax = 13'(ox + int'($urandom_range(32))); w.ay = 13'(oy + int'($urandom_range(32)));
      w.bx = 13'(ox + int'($urandom_range(32))); w.by = 13'(oy + int'($urandom_range(32)));
      w.cx = 13'(ox + int'($urandom_range(32))); w.cy = 13'(oy + int'($urandom_range(32)));
    end else begin
      w.tcol = 8'($urandom); w.trow = 7'($urandom);
      w.ax = 13'($urandom); w.ay = 13'($urandom); w.bx = 13'($urandom);
      w.by = 13'($urandom); w.cx = 13'($urandom); w.cy = 13'($urandom);
    end
    send_word(w);
  endtask

  // sink side: check on handshake, then pick next ready
  initial begin
    frag_t f;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        f.x = out_ch.pixel_x; f.y = out_ch.pixel_y; f.z = out_ch.pixel_depth;
        f.color = out_ch.pixel_color; f.last = out_ch.last;
        sb.check_frag(f);
      end
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct());
    end
  end

  initial begin
    tri_word_t w;
    sb = new();
    phase = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ActRaster;
    in_ch.vertex_a_x <= '0; in_ch.vertex_a_y <= '0; in_ch.vertex_a_depth <= '0;
    in_ch.vertex_b_x <= '0; in_ch.vertex_b_y <= '0; in_ch.vertex_b_depth <= '0;
    in_ch.vertex_c_x <= '0; in_ch.vertex_c_y <= '0; in_ch.vertex_c_depth <= '0;
    in_ch.tile_col <= '0; in_ch.tile_row <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed, reset colour
    send_tri(10, 10, 1000, 20, 12, 2000, 12, 22, 3000, 1, 1);
    send_tri(10, 10, 500, 12, 22, 500, 20, 12, 500, 1, 1);          // behind, other winding
    send_tri(10, 10, 65535, 12, 22, 65535, 20, 12, 65535, 1, 1);    // in front
    send_tri(-4096, -4096, 0, 4095, -4096, 0, -4096, 4095, 0, 0, 0);  // clamp at col/row 0
    send_tri(-4096, -4096, 65535, 4095, 4095, 65535, -4096, 4095, 65535, 3, 5);
    send_tri(4095, 4095, 1, -4096, 4095, 2, 4095, -4096, 3, 159, 89);
    send_tri(5, 5, 100, 10, 10, 200, 15, 15, 300, 0, 0);            // zero area
    send_tri(0, 0, 100, 4095, 0, 100, 0, 4095, 100, 255, 127);       // off screen
    send_tri(3, 3, 0, 3, 3, 0, 3, 3, 0, 0, 0);
    send_tri(1272, 712, 4000, 1279, 712, 4000, 1272, 719, 4000, 159, 89);
    w = '{default: 0};
    w.action = ActClear;
    send_word(w);
    send_tri(10, 10, 1, 20, 12, 1, 12, 22, 1, 1, 1);                 // store cleared
    wait_idle();
    write_fill(24'h000000);
    send_tri(-4096, -4096, 7, 4095, 0, 8, 0, 4095, 9, 7, 7);
    wait_idle();
    write_fill(24'hFFFFFF);

    for (int p = 0; p < 3; p++) begin
      phase = p;
      repeat (127) send_random();
      wait_idle();
      write_fill(24'($urandom));
    end
    phase = 2;
    send_tri(40, 40, 1234, 47, 40, 1234, 40, 47, 1234, 5, 5);
    wait_idle();

    if (sb.errors == 0) $display("triangle_depth_rasterizer_unit: match");
    else $display("triangle_depth_rasterizer_unit: mismatch");
    $finish;
  end

  initial begin
    #400000000;
    $display("triangle_depth_rasterizer_unit: mismatch");
    $finish;
  end

endmodule
